/* hw/rtl/csrmv_pkg.sv */
package csrmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_AW = 4;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_NZ    = 2'd1;
    localparam logic [1:0] MODE_EMPTY = 2'd2;

    localparam logic [1:0] REG_ALPHA      = 2'd0;
    localparam logic [1:0] REG_BETA       = 2'd1;
    localparam logic [1:0] REG_INDEX_BASE = 2'd2;

    localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [10:0]        column;
        logic signed [31:0] value;
        logic               last_in_row;
        logic signed [31:0] old_result;
    } in_t;

    typedef struct packed {
        logic signed [31:0] row_result;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic               acc;
        logic               row_end;
        logic signed [31:0] value;
        logic signed [31:0] xval;
        logic signed [31:0] old_result;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* hw/rtl/csrmv_ram.sv */
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/csrmv_front.sv */
module csrmv_front import csrmv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  in_t  item,
    input  logic push,
    output logic full,
    input  logic index_base,
    output cmd_t cmd,
    output logic cmd_push,
    input  logic cmd_full
);

    logic        accept;
    logic [11:0] diff;
    logic        in_range;
    logic        is_nz;
    logic        is_empty;
    logic [ADDR_W-1:0] addr;
    logic [31:0] xval;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_acc_reg;
    logic        s1_row_end_reg;
    logic signed [31:0] s1_value_reg;
    logic signed [31:0] s1_old_reg;

    assign full     = s1_valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = s1_valid_reg && !cmd_full;

    assign diff     = {1'b0, item.column} - {11'd0, index_base};
    assign in_range = !diff[11] && (32'(diff[10:0]) < 32'(VECTOR_DEPTH));
    assign addr     = ADDR_W'(diff[10:0]);
    assign is_nz    = item.mode == MODE_NZ;
    assign is_empty = item.mode == MODE_EMPTY;

    csrmv_ram #(
        .WIDTH (32),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (accept && item.mode == MODE_LOAD && in_range),
        .waddr (addr),
        .wdata (item.value),
        .re    (accept && is_nz),
        .raddr (addr),
        .rdata (xval)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = is_nz || is_empty;
        end
        else if (cmd_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg     <= is_nz && in_range;
            s1_row_end_reg <= (is_nz && item.last_in_row) || is_empty;
            s1_value_reg   <= item.value;
            s1_old_reg     <= item.old_result;
        end
    end

    assign cmd.acc        = s1_acc_reg;
    assign cmd.row_end    = s1_row_end_reg;
    assign cmd.value      = s1_value_reg;
    assign cmd.xval       = xval;
    assign cmd.old_result = s1_old_reg;

endmodule

/* hw/rtl/csrmv_cmdq.sv */
module csrmv_cmdq import csrmv_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    wr_cmd,
    input  logic    push,
    output cmd_t    rd_cmd,
    input  logic    pop,
    output q_stat_t stat
);

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = count_reg == CMDQ_CW'(CMDQ_DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_cmd     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* hw/rtl/csrmv_back.sv */
module csrmv_back import csrmv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  q_stat_t     q_stat,
    output logic        cmd_pop,
    input  logic [31:0] alpha,
    input  logic [31:0] beta,
    output res_t        result,
    output logic        empty,
    input  logic        pop,
    output logic        busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NZ_MUL,
        S_NZ_RND,
        S_NZ_ACC,
        S_E_MAG,
        S_E_HI,
        S_E_LO,
        S_E_B,
        S_E_RND,
        S_E_SGN,
        S_E_SUM
    } state_t;

    state_t      state_reg;
    logic        row_end_reg;
    logic        neg_reg;
    logic [31:0] opa_reg;
    logic [31:0] opb_reg;
    logic [31:0] old_reg;
    logic [63:0] prod_reg;
    logic [47:0] term_reg;
    logic [47:0] row_sum_reg;
    logic        sum_clipped_reg;
    logic [31:0] am_reg;
    logic [47:0] sm_reg;
    logic [31:0] bm_reg;
    logic [31:0] om_reg;
    logic        a_neg_reg;
    logic        b_neg_reg;
    logic [54:0] ph_reg;
    logic        big_reg;
    logic [63:0] full_reg;
    logic [48:0] ma_reg;
    logic [47:0] mb_reg;
    logic [49:0] ta_reg;
    logic [49:0] tb_reg;
    res_t        res_reg;
    logic        res_valid_reg;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [31:0] value_mag;
    logic [31:0] xval_mag;
    logic [63:0] nz_rnd;
    logic [49:0] acc_sum;
    logic        acc_fits;
    logic [63:0] a_rnd;
    logic [63:0] b_rnd;
    logic [50:0] fin_sum;
    logic        fin_fits;
    logic        res_free;

    assign cmd_pop  = state_reg == S_IDLE && !q_stat.empty;
    assign busy     = state_reg != S_IDLE;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;
    assign res_free = !res_valid_reg || pop;

    assign value_mag = cmd.value[31] ? 32'd0 - cmd.value : cmd.value;
    assign xval_mag  = cmd.xval[31] ? 32'd0 - cmd.xval : cmd.xval;

    always_comb
    begin
        case (state_reg)
            S_E_HI:
            begin
                mul_x = am_reg;
                mul_y = {8'd0, sm_reg[47:24]};
            end
            S_E_LO:
            begin
                mul_x = am_reg;
                mul_y = {8'd0, sm_reg[23:0]};
            end
            S_E_B:
            begin
                mul_x = bm_reg;
                mul_y = om_reg;
            end
            default:
            begin
                mul_x = opa_reg;
                mul_y = opb_reg;
            end
        endcase
    end

    assign mul_p = 64'(mul_x) * 64'(mul_y);

    assign nz_rnd   = prod_reg + 64'h8000;
    assign acc_sum  = {{2{row_sum_reg[47]}}, row_sum_reg} + {{2{term_reg[47]}}, term_reg};
    assign acc_fits = acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111;
    assign a_rnd    = full_reg + 64'h8000;
    assign b_rnd    = prod_reg + 64'h8000;
    assign fin_sum  = {ta_reg[49], ta_reg} + {tb_reg[49], tb_reg};
    assign fin_fits = fin_sum[50:31] == '0 || fin_sum[50:31] == '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            row_end_reg     <= 1'b0;
            neg_reg         <= 1'b0;
            opa_reg         <= '0;
            opb_reg         <= '0;
            old_reg         <= '0;
            prod_reg        <= '0;
            term_reg        <= '0;
            row_sum_reg     <= '0;
            sum_clipped_reg <= 1'b0;
            am_reg          <= '0;
            sm_reg          <= '0;
            bm_reg          <= '0;
            om_reg          <= '0;
            a_neg_reg       <= 1'b0;
            b_neg_reg       <= 1'b0;
            ph_reg          <= '0;
            big_reg         <= 1'b0;
            full_reg        <= '0;
            ma_reg          <= '0;
            mb_reg          <= '0;
            ta_reg          <= '0;
            tb_reg          <= '0;
            res_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg && state_reg != S_E_SUM)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        opa_reg     <= value_mag;
                        opb_reg     <= xval_mag;
                        neg_reg     <= cmd.value[31] ^ cmd.xval[31];
                        row_end_reg <= cmd.row_end;
                        old_reg     <= cmd.old_result;
                        if (cmd.acc)
                        begin
                            state_reg <= S_NZ_MUL;
                        end
                        else if (cmd.row_end)
                        begin
                            state_reg <= S_E_MAG;
                        end
                    end
                end
                S_NZ_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_NZ_RND;
                end
                S_NZ_RND:
                begin
                    term_reg  <= neg_reg ? 48'd0 - nz_rnd[63:16] : nz_rnd[63:16];
                    state_reg <= S_NZ_ACC;
                end
                S_NZ_ACC:
                begin
                    if (acc_fits)
                    begin
                        row_sum_reg <= acc_sum[47:0];
                    end
                    else
                    begin
                        row_sum_reg     <= acc_sum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
                        sum_clipped_reg <= 1'b1;
                    end
                    state_reg <= row_end_reg ? S_E_MAG : S_IDLE;
                end
                S_E_MAG:
                begin
                    am_reg    <= alpha[31] ? 32'd0 - alpha : alpha;
                    sm_reg    <= row_sum_reg[47] ? 48'd0 - row_sum_reg : row_sum_reg;
                    bm_reg    <= beta[31] ? 32'd0 - beta : beta;
                    om_reg    <= old_reg[31] ? 32'd0 - old_reg : old_reg;
                    a_neg_reg <= alpha[31] ^ row_sum_reg[47];
                    b_neg_reg <= beta[31] ^ old_reg[31];
                    state_reg <= S_E_HI;
                end
                S_E_HI:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_E_LO;
                end
                S_E_LO:
                begin
                    ph_reg    <= prod_reg[54:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_E_B;
                end
                S_E_B:
                begin
                    big_reg   <= |ph_reg[54:39];
                    full_reg  <= {ph_reg[39:0], 24'd0} + prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_E_RND;
                end
                S_E_RND:
                begin
                    ma_reg    <= big_reg ? 49'h1_0000_0000_0000 : {1'b0, a_rnd[63:16]};
                    mb_reg    <= (beta == '0) ? 48'd0 : b_rnd[63:16];
                    state_reg <= S_E_SGN;
                end
                S_E_SGN:
                begin
                    ta_reg    <= a_neg_reg ? 50'd0 - {1'b0, ma_reg} : {1'b0, ma_reg};
                    tb_reg    <= b_neg_reg ? 50'd0 - {2'b00, mb_reg} : {2'b00, mb_reg};
                    state_reg <= S_E_SUM;
                end
                S_E_SUM:
                begin
                    if (res_free)
                    begin
                        if (fin_fits)
                        begin
                            res_reg.row_result <= fin_sum[31:0];
                            res_reg.saturated  <= sum_clipped_reg;
                        end
                        else
                        begin
                            res_reg.row_result <= fin_sum[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            res_reg.saturated  <= 1'b1;
                        end
                        res_valid_reg   <= 1'b1;
                        row_sum_reg     <= '0;
                        sum_clipped_reg <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/csr_scaled_matvec.sv */
// A row's last nonzero passes the front-end register, the command queue and then the sequencer.
// A vector load only writes the vector store; a nonzero holds the multiply-accumulate sequencer
// in S_NZ_MUL to S_NZ_ACC and a row end in S_E_MAG to S_E_SUM, waiting for a free result,
// on the shared 32x32 multiplier. Up to 4 commands queue between front end and sequencer.
// Reset: alpha to 1.0, beta to 0, index_base to 0, accumulator and queues cleared;
// the vector store is not cleared and reads of unwritten entries are undefined.
module csr_scaled_matvec import csrmv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  in_t               item,
    input  logic              push,
    output logic              full,
    output res_t              result,
    output logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] alpha_reg;
    logic [31:0] beta_reg;
    logic        index_base_reg;
    logic        cfg_wr;

    cmd_t    q_wr_cmd;
    cmd_t    q_rd_cmd;
    logic    q_push;
    logic    q_pop;
    q_stat_t q_stat;
    logic    back_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= ALPHA_RESET;
            beta_reg       <= '0;
            index_base_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ALPHA:      alpha_reg      <= pwdata;
                REG_BETA:       beta_reg       <= pwdata;
                REG_INDEX_BASE: index_base_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ALPHA:      prdata = alpha_reg;
            REG_BETA:       prdata = beta_reg;
            REG_INDEX_BASE: prdata = {31'd0, index_base_reg};
            default:        prdata = '0;
        endcase
    end

    csrmv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .full       (full),
        .index_base (index_base_reg),
        .cmd        (q_wr_cmd),
        .cmd_push   (q_push),
        .cmd_full   (q_stat.full)
    );

    csrmv_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_cmd (q_wr_cmd),
        .push   (q_push),
        .rd_cmd (q_rd_cmd),
        .pop    (q_pop),
        .stat   (q_stat)
    );

    csrmv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_rd_cmd),
        .q_stat  (q_stat),
        .cmd_pop (q_pop),
        .alpha   (alpha_reg),
        .beta    (beta_reg),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .busy    (back_busy)
    );

`ifndef NO_ASSERTIONS
    a_full_only_on_queue_full: assert property (
        @(posedge clk) disable iff (!rst_n) full |-> q_stat.full
    ) else $error("input held off while command queue has room");

    a_result_from_sequencer: assert property (
        @(posedge clk) disable iff (!rst_n) $fell(empty) |-> $past(back_busy)
    ) else $error("result appeared without a row-end sequence");

    a_no_pop_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty
    ) else $error("command taken from an empty queue");
`endif

endmodule
